[hw/rtl/noat_pkg.sv]
// package of types, codes and constants for the order and ack tracker
`default_nettype none
package noat_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int FIFO_DEPTH_DEF    = 8;
  localparam int CFG_W             = 8;
  localparam int CFG_IDX_W         = 1;

  localparam logic [7:0] ALL_FLAGS = 8'hff;
  localparam logic [7:0] NO_FLAGS  = 8'h00;

  typedef enum logic [2:0] {
    KIND_NET_ACK   = 3'd0,
    KIND_NET_ORDER = 3'd1,
    KIND_CPU_SEND  = 3'd2,
    KIND_CPU_SYNC  = 3'd3,
    KIND_GET_ORDER = 3'd4,
    KIND_GET_WAKE  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_WAIT_SET = 3'd1,
    ST_ACKED    = 3'd2,
    ST_NO_ORDER = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_BUSY     = 3'd6,
    ST_FULL     = 3'd7
  } status_t;

  localparam logic [1:0] CMD_ACK = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_DONE_MASK    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_MASK = 1'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_id;
    logic [7:0]  ack_flags;
    logic [1:0]  order_cmd;
    logic [47:0] remote_addr;
    logic [47:0] local_word;
    logic [15:0] byte_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] resp_task_id;
    logic [7:0]  resp_ack_flags;
    logic [1:0]  resp_order_cmd;
    logic [47:0] resp_remote_addr;
    logic [47:0] resp_local_word;
    logic [15:0] resp_byte_len;
    logic        send_valid;
    logic [3:0]  orders_waiting;
    logic [3:0]  wakeups_waiting;
    logic        irq_order;
    logic        irq_wake;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_UPDATE = 2'd2,
    S_OUT    = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } dp_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/noat_if.sv]
// valid/ready channel interface
`default_nettype none
interface noat_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/noat_ctrl.sv]
// controller state machine sequencing each item
`default_nettype none
module noat_ctrl
  import noat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_LOOKUP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.capture, cmd.lookup, cmd.update}) <= 1)
    else $error("more than one datapath command");
  a_lookup_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.lookup)
    else $error("capture not followed by lookup");
  a_update_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> cmd.update)
    else $error("lookup not followed by update");
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("no result after update");
`endif

endmodule
`default_nettype wire

[hw/rtl/noat_dp.sv]
// datapath: order and wait tables, order and wakeup fifos, result register
`default_nettype none
module noat_dp
  import noat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  input  wire in_item_t             in_item,
  input  wire logic [7:0]           done_mask,
  input  wire logic [7:0]           recv_mask,
  output out_item_t                 out_item
);

  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int FW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int RX_W = 16 + 2 + 16 + 48 + 48;

  in_item_t item_r;

  logic [TABLE_ENTRIES-1:0] ord_v_r, wait_v_r;
  logic [15:0] ord_task_r [TABLE_ENTRIES];
  logic [7:0]  ord_flags_r [TABLE_ENTRIES];
  logic [15:0] wait_task_r [TABLE_ENTRIES];
  logic [7:0]  wait_flags_r [TABLE_ENTRIES];

  logic [FW-1:0] rx_head_r, wk_head_r;
  logic [CW-1:0] rx_cnt_r, wk_cnt_r;

  // lookup results registered between the two phases
  logic          ord_hit_r, wait_hit_r, ord_free_ok_r, wait_free_ok_r;
  logic [TW-1:0] ord_idx_r, wait_idx_r, ord_free_r, wait_free_r;
  logic [7:0]    ord_fl_r, wait_fl_r;

  logic          ord_hit, wait_hit, ord_free_ok, wait_free_ok;
  logic [TW-1:0] ord_idx, wait_idx, ord_free, wait_free;

  // associative search over the tables, lowest index wins
  always_comb begin
    ord_hit = 1'b0; wait_hit = 1'b0; ord_free_ok = 1'b0; wait_free_ok = 1'b0;
    ord_idx = '0; wait_idx = '0; ord_free = '0; wait_free = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (ord_v_r[i] && ord_task_r[i] == item_r.task_id) begin
        ord_hit = 1'b1; ord_idx = TW'(i);
      end
      if (wait_v_r[i] && wait_task_r[i] == item_r.task_id) begin
        wait_hit = 1'b1; wait_idx = TW'(i);
      end
      if (!ord_v_r[i]) begin
        ord_free_ok = 1'b1; ord_free = TW'(i);
      end
      if (!wait_v_r[i]) begin
        wait_free_ok = 1'b1; wait_free = TW'(i);
      end
    end
  end

  // fifo memories
  logic          rx_we, wk_we;
  logic [FW-1:0] rx_waddr, wk_waddr;
  logic [CW:0]   rx_sum, wk_sum;
  logic [RX_W-1:0] rx_wdata, rx_rdata;
  logic [23:0]   wk_wdata, wk_rdata;

  // tail address, wrapped at the fifo depth
  assign rx_sum   = (CW+1)'(rx_head_r) + (CW+1)'(rx_cnt_r);
  assign wk_sum   = (CW+1)'(wk_head_r) + (CW+1)'(wk_cnt_r);
  assign rx_waddr = (rx_sum >= (CW+1)'(FIFO_DEPTH)) ?
                    FW'(rx_sum - (CW+1)'(FIFO_DEPTH)) : FW'(rx_sum);
  assign wk_waddr = (wk_sum >= (CW+1)'(FIFO_DEPTH)) ?
                    FW'(wk_sum - (CW+1)'(FIFO_DEPTH)) : FW'(wk_sum);
  assign rx_wdata = {item_r.task_id, item_r.order_cmd, item_r.byte_len,
                     item_r.remote_addr, item_r.local_word};
  assign wk_wdata = {item_r.task_id, item_r.ack_flags};

  noat_ram #(.WIDTH(RX_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
    .raddr(rx_head_r), .rdata(rx_rdata)
  );
  noat_ram #(.WIDTH(24), .DEPTH(FIFO_DEPTH)) u_wk_ram (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_head_r), .rdata(wk_rdata)
  );

  logic is_ack;
  assign is_ack = item_r.kind == KIND_NET_ACK ||
                  (item_r.kind == KIND_NET_ORDER && item_r.order_cmd == CMD_ACK);

  logic wake_match, wk_full, rx_full;
  assign wake_match = wait_hit_r && ((wait_fl_r & item_r.ack_flags) != NO_FLAGS);
  assign wk_full    = wk_cnt_r == CW'(FIFO_DEPTH);
  assign rx_full    = rx_cnt_r == CW'(FIFO_DEPTH);

  assign rx_we = cmd.update && !is_ack && item_r.kind == KIND_NET_ORDER && !rx_full;
  assign wk_we = cmd.update && is_ack && wake_match && !wk_full;

  // update phase decisions
  out_item_t res;
  logic [CW-1:0] rx_cnt_nxt, wk_cnt_nxt;
  always_comb begin
    res        = '0;
    rx_cnt_nxt = rx_cnt_r;
    wk_cnt_nxt = wk_cnt_r;
    if (is_ack) begin
      res.status = ord_hit_r ? ST_OK : ST_UNKNOWN;
      if (wake_match) begin
        if (wk_full) res.status = ST_FULL;
        else wk_cnt_nxt = wk_cnt_r + 1'b1;
      end
    end else begin
      case (item_r.kind)
        KIND_NET_ORDER: begin
          if (rx_full) res.status = ST_FULL;
          else rx_cnt_nxt = rx_cnt_r + 1'b1;
        end
        KIND_CPU_SEND: begin
          if (item_r.order_cmd == CMD_ACK) res.send_valid = 1'b1;
          else if (ord_hit_r) res.status = ST_BUSY;
          else if (!ord_free_ok_r) res.status = ST_FULL;
          else res.send_valid = 1'b1;
        end
        KIND_CPU_SYNC: begin
          res.resp_task_id = item_r.task_id;
          if (!ord_hit_r) begin
            res.status = ST_NO_ORDER;
            res.resp_ack_flags = done_mask;
          end else if ((ord_fl_r & item_r.ack_flags) == NO_FLAGS) begin
            res.status = ST_ACKED;
            res.resp_ack_flags = item_r.ack_flags;
          end else if (!wait_hit_r && !wait_free_ok_r) begin
            res.status = ST_FULL;
          end else begin
            res.status = ST_WAIT_SET;
          end
        end
        KIND_GET_ORDER: begin
          if (rx_cnt_r == '0) res.status = ST_EMPTY;
          else begin
            {res.resp_task_id, res.resp_order_cmd, res.resp_byte_len,
             res.resp_remote_addr, res.resp_local_word} = rx_rdata;
            rx_cnt_nxt = rx_cnt_r - 1'b1;
          end
        end
        KIND_GET_WAKE: begin
          if (wk_cnt_r == '0) res.status = ST_EMPTY;
          else begin
            {res.resp_task_id, res.resp_ack_flags} = wk_rdata;
            wk_cnt_nxt = wk_cnt_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.orders_waiting  = 4'(rx_cnt_nxt);
    res.wakeups_waiting = 4'(wk_cnt_nxt);
    res.irq_order       = rx_cnt_nxt != '0;
    res.irq_wake        = wk_cnt_nxt != '0;
  end

  // item capture, lookup and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.lookup) begin
      ord_hit_r      <= ord_hit;
      wait_hit_r     <= wait_hit;
      ord_free_ok_r  <= ord_free_ok;
      wait_free_ok_r <= wait_free_ok;
      ord_idx_r      <= ord_idx;
      wait_idx_r     <= wait_idx;
      ord_free_r     <= ord_free;
      wait_free_r    <= wait_free;
      ord_fl_r       <= ord_flags_r[ord_idx];
      wait_fl_r      <= wait_flags_r[wait_idx];
    end
    if (cmd.update) out_item <= res;
  end

  // table payload writes
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (is_ack && ord_hit_r && item_r.ack_flags != done_mask)
        ord_flags_r[ord_idx_r] <= ord_fl_r & ~item_r.ack_flags;
      if (item_r.kind == KIND_CPU_SEND && item_r.order_cmd != CMD_ACK &&
          !ord_hit_r && ord_free_ok_r) begin
        ord_task_r[ord_free_r]  <= item_r.task_id;
        ord_flags_r[ord_free_r] <= ALL_FLAGS;
      end
      if (wk_we && item_r.ack_flags == recv_mask)
        wait_flags_r[wait_idx_r] <= wait_fl_r & ~item_r.ack_flags;
      if (item_r.kind == KIND_CPU_SYNC && ord_hit_r &&
          (ord_fl_r & item_r.ack_flags) != NO_FLAGS) begin
        if (wait_hit_r) begin
          wait_flags_r[wait_idx_r] <= wait_fl_r | item_r.ack_flags;
        end else if (wait_free_ok_r) begin
          wait_task_r[wait_free_r]  <= item_r.task_id;
          wait_flags_r[wait_free_r] <= item_r.ack_flags;
        end
      end
    end
  end

  // valid bits and fifo pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_v_r   <= '0;
      wait_v_r  <= '0;
      rx_head_r <= '0;
      wk_head_r <= '0;
      rx_cnt_r  <= '0;
      wk_cnt_r  <= '0;
    end else if (cmd.update) begin
      rx_cnt_r <= rx_cnt_nxt;
      wk_cnt_r <= wk_cnt_nxt;
      if (!is_ack && item_r.kind == KIND_GET_ORDER && rx_cnt_r != '0)
        rx_head_r <= (rx_head_r == FW'(FIFO_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
      if (!is_ack && item_r.kind == KIND_GET_WAKE && wk_cnt_r != '0)
        wk_head_r <= (wk_head_r == FW'(FIFO_DEPTH - 1)) ? '0 : wk_head_r + 1'b1;
      if (is_ack && ord_hit_r && item_r.ack_flags == done_mask)
        ord_v_r[ord_idx_r] <= 1'b0;
      if (item_r.kind == KIND_CPU_SEND && item_r.order_cmd != CMD_ACK &&
          !ord_hit_r && ord_free_ok_r)
        ord_v_r[ord_free_r] <= 1'b1;
      if (wk_we && item_r.ack_flags != recv_mask)
        wait_v_r[wait_idx_r] <= 1'b0;
      if (item_r.kind == KIND_CPU_SYNC && ord_hit_r && !wait_hit_r &&
          wait_free_ok_r && (ord_fl_r & item_r.ack_flags) != NO_FLAGS)
        wait_v_r[wait_free_r] <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= CW'(FIFO_DEPTH)) else $error("order fifo overfilled");
  a_wk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wk_cnt_r <= CW'(FIFO_DEPTH)) else $error("wakeup fifo overfilled");
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wk_we |-> !wk_full) else $error("wakeup write while full");
`endif

endmodule
`default_nettype wire

[hw/rtl/noat_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module noat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/noc_order_ack_tracker_top.sv]
// Top level of the order and ack tracker.
// The item is captured, looked up in the tables, then the tables are updated.
// Steps per item: table lookup, update, result handoff, which waits on out_ready.
// The next item is taken in the cycle its predecessor's result is taken.
// Synchronous active-low reset empties both fifos, clears all table valid bits
// and sets the done and receive masks to 1 and 2.
`default_nettype none
module noc_order_ack_tracker_top
  import noat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  noat_if.sink                      in_ch,
  noat_if.source                    out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [7:0] done_mask_r, recv_mask_r;
  dp_cmd_t    cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_mask_r <= 8'd1;
      recv_mask_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DONE_MASK:    done_mask_r <= cfg_data;
        REG_RECEIVE_MASK: recv_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  noat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd)
  );

  noat_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_ch.data),
    .done_mask(done_mask_r), .recv_mask(recv_mask_r), .out_item(out_ch.data)
  );

endmodule
`default_nettype wire

[verif/noc_order_ack_tracker_top_test.sv]
// self-checking testbench of the order and ack tracker top level
`timescale 1ns / 100ps
module noc_order_ack_tracker_top_test
  import noat_pkg::*;
();

  localparam int TBL = TABLE_ENTRIES_DEF;
  localparam int FDEPTH = FIFO_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 800000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  noat_if #(.T(in_item_t)) in_ch ();
  noat_if #(.T(out_item_t)) out_ch ();

  noc_order_ack_tracker_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [15:0] task_id;
    logic [1:0]  cmd;
    logic [15:0] len;
    logic [47:0] remote;
    logic [47:0] local_w;
  } rx_order_t;

  typedef struct {
    logic [15:0] task_id;
    logic [7:0]  flags;
  } wake_t;

  // tracker state as the block should hold it
  logic [7:0]  done_mask;
  logic [7:0]  recv_mask;
  bit          ord_vld [TBL];
  logic [15:0] ord_task [TBL];
  logic [7:0]  ord_flags [TBL];
  bit          wait_vld [TBL];
  logic [15:0] wait_task [TBL];
  logic [7:0]  wait_flags [TBL];
  rx_order_t   rx_orders [$];
  wake_t       wakeups [$];

  out_item_t   pending_results [$];
  int          err_cnt;
  int          cycle_cnt;
  int          hold_len;
  bit          rx_calm;

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int find_order(logic [15:0] t);
    for (int i = 0; i < TBL; i++) if (ord_vld[i] && ord_task[i] == t) return i;
    return -1;
  endfunction

  function automatic int find_wait(logic [15:0] t);
    for (int i = 0; i < TBL; i++) if (wait_vld[i] && wait_task[i] == t) return i;
    return -1;
  endfunction

  // ack from the network: order update, then waiter wakeup
  function automatic status_t apply_ack(logic [15:0] t, logic [7:0] f);
    status_t st;
    int i;
    int j;
    wake_t w;
    st = ST_OK;
    i = find_order(t);
    if (i >= 0) begin
      if (f == done_mask) ord_vld[i] = 0;
      else ord_flags[i] &= ~f;
    end else begin
      st = ST_UNKNOWN;
    end
    j = find_wait(t);
    if (j >= 0 && (wait_flags[j] & f) != NO_FLAGS) begin
      if (wakeups.size() >= FDEPTH) return ST_FULL;
      w.task_id = t;
      w.flags = f;
      wakeups.insert(wakeups.size(), w);
      if (f == recv_mask) wait_flags[j] &= ~f;
      else wait_vld[j] = 0;
    end
    return st;
  endfunction

  function automatic out_item_t predict_tracker(in_item_t it);
    out_item_t r;
    rx_order_t ro;
    wake_t w;
    int o;
    int k;
    r = '0;
    if (it.kind == KIND_NET_ACK || (it.kind == KIND_NET_ORDER && it.order_cmd == CMD_ACK)) begin
      r.status = apply_ack(it.task_id, it.ack_flags);
    end else if (it.kind == KIND_NET_ORDER) begin
      if (rx_orders.size() >= FDEPTH) begin
        r.status = ST_FULL;
      end else begin
        ro.task_id = it.task_id;
        ro.cmd = it.order_cmd;
        ro.len = it.byte_len;
        ro.remote = it.remote_addr;
        ro.local_w = it.local_word;
        rx_orders.insert(rx_orders.size(), ro);
      end
    end else if (it.kind == KIND_CPU_SEND) begin
      if (it.order_cmd == CMD_ACK) begin
        r.send_valid = 1;
      end else if (find_order(it.task_id) >= 0) begin
        r.status = ST_BUSY;
      end else begin
        k = -1;
        for (int i = TBL - 1; i >= 0; i--) if (!ord_vld[i]) k = i;
        if (k < 0) begin
          r.status = ST_FULL;
        end else begin
          ord_vld[k] = 1;
          ord_task[k] = it.task_id;
          ord_flags[k] = ALL_FLAGS;
          r.send_valid = 1;
        end
      end
    end else if (it.kind == KIND_CPU_SYNC) begin
      o = find_order(it.task_id);
      r.resp_task_id = it.task_id;
      if (o < 0) begin
        r.status = ST_NO_ORDER;
        r.resp_ack_flags = done_mask;
      end else if ((ord_flags[o] & it.ack_flags) == NO_FLAGS) begin
        r.status = ST_ACKED;
        r.resp_ack_flags = it.ack_flags;
      end else begin
        k = find_wait(it.task_id);
        if (k >= 0) begin
          wait_flags[k] |= it.ack_flags;
          r.status = ST_WAIT_SET;
        end else begin
          for (int i = TBL - 1; i >= 0; i--) if (!wait_vld[i]) k = i;
          if (k < 0) begin
            r.status = ST_FULL;
          end else begin
            wait_vld[k] = 1;
            wait_task[k] = it.task_id;
            wait_flags[k] = it.ack_flags;
            r.status = ST_WAIT_SET;
          end
        end
      end
    end else if (it.kind == KIND_GET_ORDER) begin
      if (rx_orders.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        ro = rx_orders.pop_front();
        r.resp_task_id = ro.task_id;
        r.resp_order_cmd = ro.cmd;
        r.resp_remote_addr = ro.remote;
        r.resp_local_word = ro.local_w;
        r.resp_byte_len = ro.len;
      end
    end else if (it.kind == KIND_GET_WAKE) begin
      if (wakeups.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        w = wakeups.pop_front();
        r.resp_task_id = w.task_id;
        r.resp_ack_flags = w.flags;
      end
    end
    r.orders_waiting = 4'(rx_orders.size());
    r.wakeups_waiting = 4'(wakeups.size());
    r.irq_order = rx_orders.size() != 0;
    r.irq_wake = wakeups.size() != 0;
    return r;
  endfunction

  // result receiver: random stalls, long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 0;
        hold_len--;
      end else if (stall > 0) begin
        out_ch.ready <= 0;
        stall--;
      end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        stall = pick_gap() - 1;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    out_item_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, a.status);
        check_field("resp_task_id", e.resp_task_id, a.resp_task_id);
        check_field("resp_ack_flags", e.resp_ack_flags, a.resp_ack_flags);
        check_field("resp_order_cmd", e.resp_order_cmd, a.resp_order_cmd);
        check_field("resp_remote_addr", e.resp_remote_addr, a.resp_remote_addr);
        check_field("resp_local_word", e.resp_local_word, a.resp_local_word);
        check_field("resp_byte_len", e.resp_byte_len, a.resp_byte_len);
        check_field("send_valid", e.send_valid, a.send_valid);
        check_field("orders_waiting", e.orders_waiting, a.orders_waiting);
        check_field("wakeups_waiting", e.wakeups_waiting, a.wakeups_waiting);
        check_field("irq_order", e.irq_order, a.irq_order);
        check_field("irq_wake", e.irq_wake, a.irq_wake);
      end
    end
  end

  // offer one item from a falling edge, return at a falling edge
  task automatic send_item(in_item_t it, bit no_gap = 0);
    int gap;
    in_ch.valid <= 1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), predict_tracker(it));
    @(negedge clk);
    gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic in_item_t make_item(logic [2:0] k, logic [15:0] t, logic [7:0] f,
                                         logic [1:0] c);
    in_item_t it;
    it.kind = k;
    it.task_id = t;
    it.ack_flags = f;
    it.order_cmd = c;
    it.remote_addr = 48'({$urandom, $urandom});
    it.local_word = 48'({$urandom, $urandom});
    it.byte_len = 16'($urandom);
    return it;
  endfunction

  // wait for every result, then leave the valid low
  task automatic drain();
    in_ch.valid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_DONE_MASK) done_mask = val;
    else recv_mask = val;
  endtask

  task automatic set_masks(logic [7:0] dm, logic [7:0] rm);
    write_cfg(REG_DONE_MASK, dm);
    write_cfg(REG_RECEIVE_MASK, rm);
  endtask

  // extremes, every kind and each corner named for the block
  task automatic test_directed();
    in_item_t it;
    send_item(make_item(KIND_GET_ORDER, 16'h0, NO_FLAGS, 2'd0));
    send_item(make_item(KIND_GET_WAKE, 16'h0, NO_FLAGS, 2'd0));
    send_item(make_item(KIND_NET_ACK, 16'hffff, ALL_FLAGS, 2'd3));
    send_item(make_item(KIND_CPU_SYNC, 16'hffff, ALL_FLAGS, 2'd0));
    send_item(make_item(KIND_CPU_SEND, 16'hffff, NO_FLAGS, 2'd3));
    send_item(make_item(KIND_CPU_SEND, 16'hffff, NO_FLAGS, 2'd1));
    send_item(make_item(KIND_CPU_SEND, 16'h0005, NO_FLAGS, CMD_ACK));
    send_item(make_item(KIND_CPU_SYNC, 16'hffff, 8'h06, 2'd0));
    send_item(make_item(KIND_CPU_SYNC, 16'hffff, 8'h80, 2'd0));
    send_item(make_item(KIND_NET_ACK, 16'hffff, recv_mask, 2'd0));
    send_item(make_item(KIND_NET_ACK, 16'hffff, 8'h04, 2'd0));
    send_item(make_item(KIND_CPU_SYNC, 16'hffff, 8'h06, 2'd0));
    send_item(make_item(KIND_GET_WAKE, 16'h0, NO_FLAGS, 2'd0));
    send_item(make_item(KIND_GET_WAKE, 16'h0, NO_FLAGS, 2'd0));
    send_item(make_item(KIND_NET_ORDER, 16'h0000, 8'h00, CMD_ACK));
    it = make_item(KIND_NET_ORDER, 16'hffff, ALL_FLAGS, 2'd3);
    it.remote_addr = '1;
    it.local_word = '1;
    it.byte_len = '1;
    send_item(it);
    it = make_item(KIND_NET_ORDER, 16'h0, NO_FLAGS, 2'd1);
    it.remote_addr = '0;
    it.local_word = '0;
    it.byte_len = '0;
    send_item(it);
    send_item(make_item(KIND_GET_ORDER, 16'h0, NO_FLAGS, 2'd0));
    send_item(make_item(KIND_GET_ORDER, 16'h0, NO_FLAGS, 2'd0));
    send_item(make_item(KIND_NET_ACK, 16'hffff, done_mask, 2'd0));
    send_item(make_item(KIND_CPU_SYNC, 16'hffff, ALL_FLAGS, 2'd0));
    send_item(make_item(3'd6, 16'h1234, 8'h55, 2'd2));
    send_item(make_item(3'd7, 16'hedcb, 8'haa, 2'd1));
  endtask

  function automatic logic [15:0] pick_task();
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 21));
  endfunction

  function automatic logic [7:0] pick_flags();
    case ($urandom_range(0, 5))
      0: return done_mask;
      1: return recv_mask;
      2: return ALL_FLAGS;
      default: return 8'($urandom);
    endcase
  endfunction

  // order lifecycles with random content, mixed with noise
  task automatic test_random(int n_items);
    int sent;
    logic [15:0] t;
    sent = 0;
    while (sent < n_items) begin
      t = pick_task();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_item(make_item(KIND_CPU_SEND, t, 8'($urandom), 2'($urandom_range(1, 3))));
          send_item(make_item(KIND_CPU_SYNC, t, pick_flags(), 2'($urandom)));
          if ($urandom_range(0, 1)) send_item(make_item(KIND_NET_ACK, t, recv_mask, 2'($urandom)));
          send_item(make_item(KIND_NET_ACK, t, pick_flags(), 2'($urandom)));
          if ($urandom_range(0, 2) == 0)
            send_item(make_item(KIND_NET_ACK, t, done_mask, 2'($urandom)));
          send_item(make_item(KIND_GET_WAKE, t, 8'($urandom), 2'($urandom)));
          sent += 5;
        end
        4, 5: begin
          send_item(make_item(KIND_NET_ORDER, t, 8'($urandom), 2'($urandom)));
          if ($urandom_range(0, 1)) send_item(make_item(KIND_GET_ORDER, t, 8'($urandom), 2'($urandom)));
          sent += 2;
        end
        6: begin
          send_item(make_item(KIND_CPU_SYNC, t, pick_flags(), 2'($urandom)));
          send_item(make_item(KIND_NET_ACK, t, pick_flags(), 2'($urandom)));
          sent += 2;
        end
        default: begin
          send_item(make_item(3'($urandom), t, 8'($urandom), 2'($urandom)));
          sent += 1;
        end
      endcase
    end
  endtask

  // receiver holds off while items keep coming, the sender pauses for all results, then a run with no receiver stalls
  task automatic test_backpressure();
    hold_len = 150;
    for (int i = 0; i < 12; i++)
      send_item(make_item(3'($urandom_range(0, 5)), pick_task(), pick_flags(), 2'($urandom)), 1);
    drain();
    rx_calm = 1;
    for (int i = 0; i < 30; i++)
      send_item(make_item(3'($urandom_range(0, 5)), pick_task(), pick_flags(), 2'($urandom)), 1);
    drain();
    rx_calm = 0;
  endtask

  initial begin
    err_cnt = 0;
    hold_len = 0;
    rx_calm = 0;
    done_mask = 8'd1;
    recv_mask = 8'd2;
    foreach (ord_vld[i]) begin
      ord_vld[i] = 0;
      wait_vld[i] = 0;
    end
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    test_directed();
    test_random(250);
    set_masks(8'd255, 8'd1);
    test_random(200);
    test_backpressure();
    set_masks(8'd1, 8'd255);
    test_random(200);
    set_masks(8'h80, 8'h40);
    test_random(150);
    set_masks(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    test_random(200);

    drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/noat_pkg.sv
hw/rtl/noat_if.sv
hw/rtl/noat_ctrl.sv
hw/rtl/noat_dp.sv
hw/rtl/noat_ram.sv
hw/rtl/noc_order_ack_tracker_top.sv
verif/noc_order_ack_tracker_top_test.sv
